>>> rtl/core/swcd_pkg.sv
// Package for the stop-and-wait command dispatcher.
// Types, constants and command codes; no dependencies.
package swcd_pkg;

    localparam int QueueDepthDefault   = 256;
    localparam int HistoryDepthDefault = 16;
    localparam logic [15:0] AckTimeoutReset = 16'd100;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RESP = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND_RD,
        ST_SEARCH,
        ST_FLUSH_RD,
        ST_FLUSH_GO,
        ST_DONE
    } t_state;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/swcd_history.sv
// History ring of sent commands in one synchronous memory.
// Depends on swcd_pkg.
module swcd_history import swcd_pkg::*; #(
    parameter int HISTORY_DEPTH = HistoryDepthDefault,
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [HW-1:0] i_waddr,
    input  logic [108:0]  i_wdata,
    input  logic [HW-1:0] i_raddr,
    output logic [108:0]  o_rdata
);
    // entry: {acked, sent_time[31:0], length[3:0], command[7:0], payload[63:0]}
    logic [108:0] r_mem [HISTORY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/stop_and_wait_command_dispatcher_unit.sv
// Top level of the stop-and-wait command dispatcher.
// Depends on swcd_pkg and swcd_history.
//
// channel | direction | handshake
// input   | in        | i_valid / o_stall
// result  | out       | o_valid / i_stall
// config  | in        | i_cfg_we (no stall)
//
// Send: SEND_RD, DONE; tick: FLUSH_RD, FLUSH_GO, DONE; response: SEARCH per entry,
// FLUSH_RD, FLUSH_GO on a match, DONE. One history read per cycle paces the search.
// Reset is synchronous; all control state cleared, memories left undefined.
// A waiting result holds in the output register; next item is taken once it goes.
module stop_and_wait_command_dispatcher_unit import swcd_pkg::*; #(
    parameter int QUEUE_DEPTH   = QueueDepthDefault,
    parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_bus_command,
    input  logic [3:0]  i_data_length,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_tick_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_transmit_valid,
    output logic [7:0]  o_transmit_command,
    output logic [3:0]  o_transmit_length,
    output logic [63:0] o_transmit_payload,
    output logic        o_ack_matched,
    output logic [31:0] o_ack_latency,
    output logic        o_queue_dropped
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HF = $clog2(HISTORY_DEPTH + 1);

    t_state r_state, n_state;
    logic [15:0] r_timeout;
    logic [31:0] r_time;
    logic [QW-1:0] r_qhead;
    logic [QW:0]   r_qcount;
    logic [HW-1:0] r_hnewest;
    logic [HF-1:0] r_hfill;
    logic [HF-1:0] r_idx;
    logic [HW-1:0] r_ent;

    logic [7:0]  r_code;
    logic [3:0]  r_len;
    logic [63:0] r_data;

    logic [75:0] r_qmem [QUEUE_DEPTH];
    logic [75:0] r_qrd;

    logic          h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [108:0]  h_wdata, h_rdata;

    logic r_ovalid;

    swcd_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(h_raddr),
        .o_rdata(h_rdata)
    );

    function automatic logic [HW-1:0] hnext(input logic [HW-1:0] a);
        if (HISTORY_DEPTH == 1) return '0;
        return (32'(a) == HISTORY_DEPTH - 1) ? '0 : a + 1'b1;
    endfunction
    function automatic logic [HW-1:0] hprev(input logic [HW-1:0] a);
        if (HISTORY_DEPTH == 1) return '0;
        return (a == '0) ? HW'(HISTORY_DEPTH - 1) : a - 1'b1;
    endfunction

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;

    // newest entry of the history is read in the memory (h_raddr = r_hnewest)
    logic last_done;
    assign last_done = (r_hfill == '0) || h_rdata[108] ||
                       ((r_time - h_rdata[107:76]) >= {16'd0, r_timeout});

    logic hit;
    assign hit = !h_rdata[108] && (h_rdata[75:64] == {r_len, r_code}) &&
                 (((h_rdata[63:0] ^ r_data) & byte_mask(r_len)) == '0);

    logic search_end;
    assign search_end = (r_idx == r_hfill);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_SEND: n_state = ST_SEND_RD;
                        CMD_RESP: n_state = ST_SEARCH;
                        CMD_TICK: n_state = ST_FLUSH_RD;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_SEND_RD:  n_state = ST_DONE;
            ST_SEARCH: begin
                if (r_idx != '0 && hit) n_state = ST_FLUSH_RD;
                else if (search_end) n_state = ST_DONE;
            end
            ST_FLUSH_RD: n_state = ST_FLUSH_GO;
            ST_FLUSH_GO: n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // history read address: newest except while searching
    always_comb begin
        h_raddr = r_hnewest;
        if (r_state == ST_IDLE && accept && t_cmd'(i_command) == CMD_RESP) begin
            h_raddr = r_hnewest;
        end else if (r_state == ST_SEARCH) begin
            h_raddr = (r_idx == '0) ? r_ent : hprev(r_ent);
        end
    end

    // transmit decisions
    logic send_now, send_drop, send_q, flush_go, ack_wr;
    assign send_now  = (r_state == ST_SEND_RD) && (r_qcount == '0) && last_done;
    assign send_drop = (r_state == ST_SEND_RD) && !send_now &&
                       (32'(r_qcount) >= QUEUE_DEPTH);
    assign send_q    = (r_state == ST_SEND_RD) && !send_now && !send_drop;
    assign flush_go  = (r_state == ST_FLUSH_GO) && (r_qcount != '0) && last_done;
    assign ack_wr    = (r_state == ST_SEARCH) && (r_idx != '0) && hit;

    always_comb begin
        h_we    = 1'b0;
        h_waddr = hnext(r_hnewest);
        h_wdata = {1'b0, r_time, r_len, r_code, r_data};
        if (ack_wr) begin
            h_we    = 1'b1;
            h_waddr = r_ent;
            h_wdata = {1'b1, h_rdata[107:0]};
        end else if (send_now) begin
            h_we = 1'b1;
        end else if (flush_go) begin
            h_we    = 1'b1;
            h_wdata = {1'b0, r_time, r_qrd};
        end
    end

    logic [QW:0]   qsum;
    logic [QW-1:0] qtail;
    assign qsum  = {1'b0, r_qhead} + r_qcount;
    assign qtail = (32'(qsum) >= QUEUE_DEPTH) ? QW'(32'(qsum) - QUEUE_DEPTH) : qsum[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (send_q) begin
            r_qmem[qtail] <= {r_len, r_code, r_data};
        end
        r_qrd <= r_qmem[r_qhead];
        if (accept) begin
            r_code <= i_bus_command;
            r_len  <= i_data_length;
            r_data <= i_payload;
        end
        if (r_state == ST_IDLE) begin
            o_transmit_valid   <= o_transmit_valid & r_ovalid;
            if (accept) begin
                o_transmit_valid   <= 1'b0;
                o_transmit_command <= '0;
                o_transmit_length  <= '0;
                o_transmit_payload <= '0;
                o_ack_matched      <= 1'b0;
                o_ack_latency      <= '0;
                o_queue_dropped    <= 1'b0;
            end
        end
        if (send_now) begin
            o_transmit_valid   <= 1'b1;
            o_transmit_command <= r_code;
            o_transmit_length  <= r_len;
            o_transmit_payload <= r_data;
        end
        if (send_drop) o_queue_dropped <= 1'b1;
        if (ack_wr) begin
            o_ack_matched <= 1'b1;
            o_ack_latency <= r_time - h_rdata[107:76];
        end
        if (flush_go) begin
            o_transmit_valid   <= 1'b1;
            o_transmit_command <= r_qrd[71:64];
            o_transmit_length  <= r_qrd[75:72];
            o_transmit_payload <= r_qrd[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_timeout <= AckTimeoutReset;
            r_time    <= '0;
            r_qhead   <= '0;
            r_qcount  <= '0;
            r_hnewest <= '0;
            r_hfill   <= '0;
            r_idx     <= '0;
            r_ent     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
            if (accept && t_cmd'(i_command) == CMD_TICK) r_time <= i_tick_time;
            if (accept) begin
                r_idx <= '0;
                r_ent <= r_hnewest;
            end
            if (r_state == ST_SEARCH && !(r_idx != '0 && hit) && !search_end) begin
                if (r_idx != '0) r_ent <= hprev(r_ent);
                r_idx <= r_idx + 1'b1;
            end
            if (send_q) r_qcount <= r_qcount + 1'b1;
            if (send_now || flush_go) begin
                r_hnewest <= hnext(r_hnewest);
                if (32'(r_hfill) < HISTORY_DEPTH) r_hfill <= r_hfill + 1'b1;
            end
            if (flush_go) begin
                r_qhead  <= (32'(r_qhead) == QUEUE_DEPTH - 1) ? '0 : r_qhead + 1'b1;
                r_qcount <= r_qcount - 1'b1;
            end
        end
    end

    // the search runs at most over the filled entries
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_hfill) else $error("search index past history fill");
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({send_now, flush_go, ack_wr, send_drop}))
        else $error("more than one history event in a cycle");
    a_qcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_qcount) <= QUEUE_DEPTH) else $error("queue count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input taken while busy");
endmodule

>>> test/swcd_checker.sv
// Scoreboard for the stop-and-wait command dispatcher: mirrors queue, history and
// timeout state from observed input beats and compares each result beat.
// Depends on swcd_pkg.
`timescale 1ns / 1ps
module swcd_checker import swcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_bus_command,
    input  logic [3:0]  i_data_length,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_tick_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_transmit_valid,
    input  logic [7:0]  i_transmit_command,
    input  logic [3:0]  i_transmit_length,
    input  logic [63:0] i_transmit_payload,
    input  logic        i_ack_matched,
    input  logic [31:0] i_ack_latency,
    input  logic        i_queue_dropped,
    output int          o_errors,
    output int          o_pending,
    output int          o_queued
);

    localparam int QD = QueueDepthDefault;
    localparam int HD = HistoryDepthDefault;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_cmd;
        logic [3:0]  tx_len;
        logic [63:0] tx_data;
        logic        matched;
        logic [31:0] latency;
        logic        dropped;
    } t_outcome;

    t_outcome    outcomes[$];
    logic [63:0] q_data[QD];
    logic [11:0] q_hdr[QD];
    int          q_head, q_count;
    logic [63:0] h_data[HD];
    logic [11:0] h_hdr[HD];
    logic [31:0] h_time[HD];
    logic        h_acked[HD];
    int          h_newest, h_fill;
    logic [31:0] now_ticks;
    logic [15:0] timeout;

    assign o_pending = outcomes.size();
    assign o_queued  = q_count;

    function automatic logic prior_done();
        if (h_fill == 0 || h_acked[h_newest]) return 1'b1;
        return (now_ticks - h_time[h_newest]) >= {16'd0, timeout};
    endfunction

    function automatic void send_now(input logic [11:0] hdr, input logic [63:0] d,
                                     inout t_outcome r);
        h_newest = (h_newest + 1) % HD;
        h_data[h_newest]  = d;
        h_hdr[h_newest]   = hdr;
        h_time[h_newest]  = now_ticks;
        h_acked[h_newest] = 1'b0;
        if (h_fill < HD) h_fill++;
        r.tx_valid = 1'b1;
        r.tx_cmd   = hdr[7:0];
        r.tx_len   = hdr[11:8];
        r.tx_data  = d;
    endfunction

    function automatic void drain_one(inout t_outcome r);
        if (q_count != 0 && prior_done()) begin
            send_now(q_hdr[q_head], q_data[q_head], r);
            q_head = (q_head + 1) % QD;
            q_count--;
        end
    endfunction

    function automatic void predict(input t_cmd cmd, input logic [7:0] code,
                                    input logic [3:0] len, input logic [63:0] d,
                                    input logic [31:0] tt);
        t_outcome    r;
        logic [11:0] hdr;
        logic [63:0] m;
        int          e;
        r   = '0;
        hdr = {len, code};
        m   = (len >= 8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
        case (cmd)
            CMD_SEND: begin
                if (q_count == 0 && prior_done()) send_now(hdr, d, r);
                else if (q_count >= QD) r.dropped = 1'b1;
                else begin
                    q_data[(q_head + q_count) % QD] = d;
                    q_hdr[(q_head + q_count) % QD]  = hdr;
                    q_count++;
                end
            end
            CMD_RESP: begin
                for (int i = 0; i < h_fill; i++) begin
                    e = (h_newest + HD - i) % HD;
                    if (!h_acked[e] && h_hdr[e] == hdr && ((h_data[e] ^ d) & m) == 0) begin
                        h_acked[e] = 1'b1;
                        r.matched  = 1'b1;
                        r.latency  = now_ticks - h_time[e];
                        drain_one(r);
                        break;
                    end
                end
            end
            CMD_TICK: begin
                now_ticks = tt;
                drain_one(r);
            end
            default: ;
        endcase
        outcomes.push_back(r);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        if (!i_rst_n) begin
            outcomes.delete();
            q_head = 0; q_count = 0; h_newest = 0; h_fill = 0;
            now_ticks = '0; timeout = AckTimeoutReset;
        end else begin
            if (i_cfg_we) timeout = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (outcomes.size() == 0) report("unexpected beat", 0, 0);
                else begin
                    w = outcomes.pop_front();
                    if (i_transmit_valid !== w.tx_valid)
                        report("transmit_valid", i_transmit_valid, w.tx_valid);
                    if (i_transmit_command !== w.tx_cmd)
                        report("transmit_command", i_transmit_command, w.tx_cmd);
                    if (i_transmit_length !== w.tx_len)
                        report("transmit_length", i_transmit_length, w.tx_len);
                    if (i_transmit_payload !== w.tx_data)
                        report("transmit_payload", i_transmit_payload, w.tx_data);
                    if (i_ack_matched !== w.matched)
                        report("ack_matched", i_ack_matched, w.matched);
                    if (i_ack_latency !== w.latency)
                        report("ack_latency", i_ack_latency, w.latency);
                    if (i_queue_dropped !== w.dropped)
                        report("queue_dropped", i_queue_dropped, w.dropped);
                end
            end
            if (i_valid && !i_in_stall)
                predict(t_cmd'(i_command), i_bus_command, i_data_length, i_payload, i_tick_time);
        end
    end

    initial o_errors = 0;

endmodule

>>> test/tb.sv
// Testbench top for stop_and_wait_command_dispatcher_unit: clock, reset, stimulus
// and verdict. Depends on swcd_pkg, swcd_checker and the RTL.
`timescale 1ns / 1ps
module tb;
    import swcd_pkg::*;

    logic        clk = 1'b0, rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
    logic [1:0]  command = CMD_NONE;
    logic [7:0]  bus_command = '0;
    logic [3:0]  data_length = '0;
    logic [63:0] payload = '0;
    logic [31:0] tick_time = '0;
    logic        tx_valid, matched, dropped;
    logic [7:0]  tx_cmd;
    logic [3:0]  tx_len;
    logic [63:0] tx_data;
    logic [31:0] latency;
    int          errors, pending, queued;
    int          send_idle = 0, recv_idle = 0;
    logic [31:0] now_ticks = '0;
    logic [7:0]  last_code;
    logic [3:0]  last_len;
    logic [63:0] last_data;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stop_and_wait_command_dispatcher_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_command(command),
        .i_bus_command(bus_command), .i_data_length(data_length), .i_payload(payload),
        .i_tick_time(tick_time), .o_valid(out_valid), .i_stall(out_stall),
        .o_transmit_valid(tx_valid), .o_transmit_command(tx_cmd),
        .o_transmit_length(tx_len), .o_transmit_payload(tx_data),
        .o_ack_matched(matched), .o_ack_latency(latency), .o_queue_dropped(dropped)
    );

    swcd_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_command(command),
        .i_bus_command(bus_command), .i_data_length(data_length), .i_payload(payload),
        .i_tick_time(tick_time), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_transmit_valid(tx_valid), .i_transmit_command(tx_cmd),
        .i_transmit_length(tx_len), .i_transmit_payload(tx_data),
        .i_ack_matched(matched), .i_ack_latency(latency), .i_queue_dropped(dropped),
        .o_errors(errors), .o_pending(pending), .o_queued(queued)
    );

    always @(negedge clk) begin
        out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
    end

    task automatic put_beat(input t_cmd cmd, input logic [7:0] code, input logic [3:0] len,
                            input logic [63:0] d, input logic [31:0] tt);
        while ((send_idle != 0) && ($urandom_range(99) < send_idle)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command <= cmd; bus_command <= code; data_length <= len;
        payload <= d; tick_time <= tt; in_valid <= 1'b1;
        if (cmd == CMD_SEND) begin
            last_code = code; last_len = len; last_data = d;
        end
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_and_wait();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        drain_and_wait();
        cfg_data <= v; cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int          pick;
        logic [63:0] d;
        pick = $urandom_range(99);
        if (pick < 40) begin
            put_beat(CMD_SEND, 8'($urandom_range(7) == 0 ? $urandom : $urandom_range(3)),
                     4'($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(8)),
                     rnd64(), $urandom);
        end else if (pick < 70) begin
            d = last_data;
            if ($urandom_range(4) == 0) d ^= 64'd1 << $urandom_range(63);
            put_beat(CMD_RESP, $urandom_range(9) == 0 ? 8'($urandom) : last_code,
                     last_len, d, $urandom);
        end else if (pick < 97) begin
            now_ticks += $urandom_range(9) == 0 ? $urandom : $urandom_range(60);
            put_beat(CMD_TICK, 8'($urandom), 4'($urandom), rnd64(), now_ticks);
        end else begin
            put_beat(CMD_NONE, 8'($urandom), 4'($urandom), rnd64(), $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats
        put_beat(CMD_RESP, 8'h00, 4'd0, '0, '0);
        put_beat(CMD_SEND, 8'hFF, 4'd8, '1, '0);
        put_beat(CMD_SEND, 8'h00, 4'd0, '0, '1);
        put_beat(CMD_SEND, 8'h12, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0, '0);
        put_beat(CMD_RESP, 8'hFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        put_beat(CMD_TICK, '0, '0, '0, 32'd7);
        put_beat(CMD_RESP, 8'hFF, 4'd8, '1, '0);
        put_beat(CMD_RESP, 8'hFF, 4'd8, '1, '0);
        put_beat(CMD_TICK, '1, '1, '1, 32'd200);
        put_beat(CMD_RESP, 8'h12, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0, '0);
        put_beat(CMD_NONE, '1, '1, '1, '1);
        put_beat(CMD_TICK, '0, '0, '0, 32'hFFFF_FFF0);
        put_beat(CMD_TICK, '0, '0, '0, 32'd5);
        put_beat(CMD_SEND, 8'h33, 4'd2, 64'h1111_2222_3333_4444, '0);
        put_beat(CMD_RESP, 8'h33, 4'd2, 64'h9999_8888_7777_4444, '0);
        now_ticks = 32'd5;

        set_timeout(16'd0);
        for (int k = 0; k < 6; k++) put_beat(CMD_SEND, 8'(k), 4'd1, 64'(k), '0);
        set_timeout(16'hFFFF);
        put_beat(CMD_SEND, 8'h40, 4'd3, rnd64(), '0);
        for (int k = 0; k < 262; k++) begin
            put_beat(CMD_SEND, 8'($urandom), 4'($urandom), rnd64(), '0);
        end
        while (queued != 0) begin
            now_ticks += 32'h0001_0000;
            put_beat(CMD_TICK, '0, '0, '0, now_ticks);
        end
        set_timeout(16'd30);

        send_idle = 8; recv_idle = 49;
        for (int k = 0; k < 400; k++) random_item();
        drain_and_wait();
        set_timeout(16'd1);
        send_idle = 49; recv_idle = 8;
        for (int k = 0; k < 400; k++) random_item();
        drain_and_wait();
        set_timeout(16'd100);
        send_idle = 0; recv_idle = 0;
        for (int k = 0; k < 400; k++) random_item();

        drain_and_wait();
        if (errors == 0) $display("stop_and_wait_command_dispatcher_unit regression: pass");
        else $display("stop_and_wait_command_dispatcher_unit regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("stop_and_wait_command_dispatcher_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/swcd_pkg.sv
rtl/core/swcd_history.sv
rtl/core/stop_and_wait_command_dispatcher_unit.sv
test/swcd_checker.sv
test/tb.sv
